// ----- rtl/core/priority_aging_job_scheduler_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the scheduler
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_AGING_JOB_SCHEDULER_DEFINES_SVH
`define PRIORITY_AGING_JOB_SCHEDULER_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define PAJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define PAJ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ----- rtl/core/paj_pkg.sv -----
// ----------------------------------------------------------------------------
// Scheduler package
// Widths, codes, the slot row layout and the control and status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package paj_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int TAG_W   = 16;
  localparam int TIME_W  = 24;
  localparam int BURST_W = 14;
  localparam int PRIO_W  = 7;
  localparam int STAT_W  = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 2'd2;

  localparam logic [PRIO_W-1:0] THRESH_RST = 7'd5;
  localparam logic [PRIO_W-1:0] STEP_RST   = 7'd1;

  localparam logic MODE_PRIO = 1'b0;
  localparam logic MODE_SRTF = 1'b1;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [STAT_W-1:0] STAT_ADDED  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SERVED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IDLE   = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [BURST_W-1:0] remaining;
    logic [PRIO_W-1:0]  prio;
  } row_t;

  typedef struct packed {
    logic             accept;
    logic             add;
    logic             rd_en;
    logic [IDX_W-1:0] rd_idx;
    logic             fin1;
    logic             fin2;
    logic             fin3;
  } cmd_t;

  typedef struct packed {
    logic have;
  } sts_t;

endpackage

// ----- rtl/core/paj_ctrl.sv -----
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences the add, slot scan and finish steps of each accepted beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_aging_job_scheduler_defines.svh"

module paj_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          opcode_i,
  input  paj_pkg::sts_t sts_i,
  output paj_pkg::cmd_t cmd_o,
  output logic          busy_o
);
  import paj_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ADD   = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_FIN1  = 3'd4;
  localparam logic [2:0] ST_FIN2  = 3'd5;
  localparam logic [2:0] ST_FIN3  = 3'd6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o         = '0;
    cmd_o.rd_idx  = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = (opcode_i == OP_ADD) ? ST_ADD : ST_SCAN;
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_IDLE;
      end
      ST_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN1;
      end
      ST_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = sts_i.have ? ST_FIN2 : ST_IDLE;
      end
      ST_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d    = ST_FIN3;
      end
      ST_FIN3: begin
        cmd_o.fin3 = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `PAJ_ASSERT(a_busy_after_accept, accept |=> busy_o, "Controller not busy after an accepted beat.")
  `PAJ_ASSERT(a_scan_ends, (state_q == ST_SCAN) && (cnt_q == LAST_IDX) |=> (state_q == ST_DRAIN), "Scan did not end after the last slot.")
  `PAJ_ASSERT_NEVER(a_state_legal, state_q > ST_FIN3, "Controller reached an unused state.")

endmodule

// ----- rtl/core/paj_datapath.sv -----
// ----------------------------------------------------------------------------
// Scheduler datapath
// Holds the job table, time counter and settings; ages, selects and retires.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_aging_job_scheduler_defines.svh"

module paj_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  paj_pkg::cmd_t                    cmd_i,
  output paj_pkg::sts_t                    sts_o,
  input  logic                             cfg_we_i,
  input  logic [paj_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [paj_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [paj_pkg::TAG_W-1:0]        job_tag_i,
  input  logic [paj_pkg::BURST_W-1:0]      burst_len_i,
  input  logic [paj_pkg::PRIO_W-1:0]       prio_level_i,
  output logic                             res_valid_o,
  output logic [paj_pkg::STAT_W-1:0]       status_o,
  output logic [paj_pkg::TAG_W-1:0]        served_tag_o,
  output logic                             finished_o,
  output logic [paj_pkg::TIME_W-1:0]       completion_time_o,
  output logic [paj_pkg::TIME_W-1:0]       turnaround_o,
  output logic [paj_pkg::TIME_W-1:0]       wait_time_o
);
  import paj_pkg::*;

  logic              mode_q;
  logic [PRIO_W-1:0] thr_q, step_q;

  logic [TIME_W-1:0]  now_q, now_inc;
  logic [SLOTS-1:0]   valid_q;
  row_t               mem_q [SLOTS];
  row_t               rd_q;

  logic [TAG_W-1:0]   tag_in_q;
  logic [BURST_W-1:0] burst_in_q;
  logic [PRIO_W-1:0]  prio_in_q;

  logic               ev_q;
  logic [IDX_W-1:0]   ev_idx_q;
  logic               have_q;
  logic [BURST_W-1:0] best_q;
  logic [IDX_W-1:0]   pick_idx_q;
  row_t               pick_q;

  logic [BURST_W-1:0] rem_new_q;
  logic               done_q;
  logic [TIME_W-1:0]  turn_q;

  logic               res_valid_q;
  logic [STAT_W-1:0]  status_q;
  logic [TAG_W-1:0]   served_tag_q;
  logic               finished_q;
  logic [TIME_W-1:0]  ctime_q, turn_out_q, wait_out_q;

  logic [IDX_W-1:0]   free_idx;
  logic               full;
  logic               ev_vld, age_hit, take;
  logic [TIME_W-1:0]  elapsed;
  logic [PRIO_W-1:0]  aged_prio, new_prio;
  logic [BURST_W-1:0] key;
  row_t               ev_row;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  row_t               mem_wd;

  assign sts_o.have = have_q;
  assign now_inc    = (now_q == TIME_MAX) ? now_q : now_q + 1'b1;

  always_comb begin
    free_idx = '0;
    full     = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
        full     = 1'b0;
      end
    end
  end

  always_comb begin
    elapsed   = now_q - rd_q.arrival;
    ev_vld    = ev_q && valid_q[ev_idx_q];
    age_hit   = (mode_q == MODE_PRIO) && (now_q >= rd_q.arrival) &&
                (elapsed > TIME_W'(thr_q));
    aged_prio = (rd_q.prio > step_q) ? rd_q.prio - step_q : '0;
    new_prio  = age_hit ? aged_prio : rd_q.prio;
    key       = (mode_q == MODE_SRTF) ? rd_q.remaining : BURST_W'(new_prio);
    take      = ev_vld && (!have_q || (key < best_q));
    ev_row      = rd_q;
    ev_row.prio = new_prio;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = ev_idx_q;
    mem_wd = ev_row;
    if (cmd_i.add) begin
      mem_we           = !full;
      mem_wa           = free_idx;
      mem_wd.tag       = tag_in_q;
      mem_wd.arrival   = now_q;
      mem_wd.burst     = burst_in_q;
      mem_wd.remaining = burst_in_q;
      mem_wd.prio      = prio_in_q;
    end else if (cmd_i.fin2) begin
      mem_we           = 1'b1;
      mem_wa           = pick_idx_q;
      mem_wd           = pick_q;
      mem_wd.remaining = rem_new_q;
    end else if (ev_vld && age_hit) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[cmd_i.rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PRIO;
      thr_q  <= THRESH_RST;
      step_q <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MODE:   mode_q <= cfg_data_i[0];
        CFG_THRESH: thr_q  <= cfg_data_i;
        CFG_STEP:   step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tag_in_q   <= job_tag_i;
      burst_in_q <= burst_len_i;
      prio_in_q  <= prio_level_i;
    end
    if (take) begin
      best_q     <= key;
      pick_idx_q <= ev_idx_q;
      pick_q     <= ev_row;
    end
    if (cmd_i.fin1) begin
      rem_new_q <= (pick_q.remaining == '0) ? '0 : pick_q.remaining - 1'b1;
    end
    if (cmd_i.fin2) begin
      done_q <= (rem_new_q == '0);
      turn_q <= (now_q >= pick_q.arrival) ? now_q - pick_q.arrival : '0;
    end
    ev_idx_q <= cmd_i.rd_idx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q   <= '0;
      valid_q <= '0;
      ev_q    <= 1'b0;
      have_q  <= 1'b0;
    end else begin
      ev_q <= cmd_i.rd_en;
      if (cmd_i.accept) begin
        have_q <= 1'b0;
      end else if (take) begin
        have_q <= 1'b1;
      end
      if (cmd_i.fin1) begin
        now_q <= now_inc;
      end
      if (cmd_i.add && !full) begin
        valid_q[free_idx] <= 1'b1;
      end
      if (cmd_i.fin2 && (rem_new_q == '0)) begin
        valid_q[pick_idx_q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.add || (cmd_i.fin1 && !have_q) || cmd_i.fin3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add || cmd_i.fin1 || cmd_i.fin3) begin
      status_q     <= STAT_IDLE;
      served_tag_q <= '0;
      finished_q   <= 1'b0;
      ctime_q      <= '0;
      turn_out_q   <= '0;
      wait_out_q   <= '0;
      if (cmd_i.add) begin
        status_q <= full ? STAT_FULL : STAT_ADDED;
      end else if (cmd_i.fin3) begin
        status_q     <= STAT_SERVED;
        served_tag_q <= pick_q.tag;
        finished_q   <= done_q;
        if (done_q) begin
          ctime_q    <= now_q;
          turn_out_q <= turn_q;
          wait_out_q <= (turn_q >= TIME_W'(pick_q.burst)) ?
                        turn_q - TIME_W'(pick_q.burst) : '0;
        end
      end
    end
  end

  assign res_valid_o       = res_valid_q;
  assign status_o          = status_q;
  assign served_tag_o      = served_tag_q;
  assign finished_o        = finished_q;
  assign completion_time_o = ctime_q;
  assign turnaround_o      = turn_out_q;
  assign wait_time_o       = wait_out_q;

  `PAJ_ASSERT(a_single_strobe, res_valid_q |=> !res_valid_q, "Result strobe lasted more than one cycle.")
  `PAJ_ASSERT(a_retire_frees, cmd_i.fin2 && (rem_new_q == '0) |=> !valid_q[pick_idx_q], "Finished job still holds its slot.")
  `PAJ_ASSERT(a_full_keeps, cmd_i.add && full |=> $stable(valid_q), "Add to a full table changed the slot map.")
  `PAJ_ASSERT_NEVER(a_fin_without_pick, cmd_i.fin2 && !have_q, "Finish step ran with no job picked.")

endmodule

// ----- rtl/core/priority_aging_job_scheduler.sv -----
// Add beat: the add state writes the slot and registers the strobe; busy is high in it.
// Tick beat: the controller reads one slot per cycle in the scan state, then drains and
// runs the finish steps; a tick that finds no job ends after the first finish step.
// One beat is in flight at a time; the next start is taken once busy drops.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset clears the time counter and slot map, restores default settings; no clearing pass.
// ----------------------------------------------------------------------------
// Priority aging job scheduler
// Job table with priority aging or shortest remaining work service per tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module priority_aging_job_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode_i,
  input  logic [paj_pkg::TAG_W-1:0]      job_tag_i,
  input  logic [paj_pkg::BURST_W-1:0]    burst_len_i,
  input  logic [paj_pkg::PRIO_W-1:0]     prio_level_i,
  input  logic                           cfg_we_i,
  input  logic [paj_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [paj_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                           res_valid_o,
  output logic [paj_pkg::STAT_W-1:0]     status_o,
  output logic [paj_pkg::TAG_W-1:0]      served_tag_o,
  output logic                           finished_o,
  output logic [paj_pkg::TIME_W-1:0]     completion_time_o,
  output logic [paj_pkg::TIME_W-1:0]     turnaround_o,
  output logic [paj_pkg::TIME_W-1:0]     wait_time_o
);
  import paj_pkg::*;

  cmd_t cmd;
  sts_t sts;

  paj_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  paj_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .job_tag_i         (job_tag_i),
    .burst_len_i       (burst_len_i),
    .prio_level_i      (prio_level_i),
    .res_valid_o       (res_valid_o),
    .status_o          (status_o),
    .served_tag_o      (served_tag_o),
    .finished_o        (finished_o),
    .completion_time_o (completion_time_o),
    .turnaround_o      (turnaround_o),
    .wait_time_o       (wait_time_o)
  );

endmodule
